@@ rtl/crc64u_pkg.sv @@
`timescale 1ns / 1ps
package crc64u_pkg;

	// Widths of the data path
	localparam int CRC_W     = 64;
	localparam int BYTE_W    = 8;
	localparam int LANES     = 8;
	localparam int CNT_W     = 4;
	localparam int LANE_IDX_W = $clog2(LANES);
	localparam int CFG_IDX_W = 1;

	// Register indexes of the config port
	localparam logic [CFG_IDX_W-1:0] REG_POLY = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_SEED = 1'b1;

	// Register reset values
	localparam logic [CRC_W-1:0] POLY_RESET = 64'hC96C_5795_D787_0F42;
	localparam logic [CRC_W-1:0] SEED_RESET = 64'h0;
	localparam logic [CRC_W-1:0] BYTE_MASK  = 64'hFF;

	// Queue depths
	localparam int MID_DEPTH = 4;
	localparam int MID_PTR_W = $clog2(MID_DEPTH);
	localparam int MID_CNT_W = $clog2(MID_DEPTH + 1);
	localparam int OUT_DEPTH = 4;
	localparam int OUT_PTR_W = $clog2(OUT_DEPTH);
	localparam int OUT_CNT_W = $clog2(OUT_DEPTH + 1) + 1;

	// One word between front and back: data-only remainder plus control
	typedef struct packed {
		logic             restart;
		logic [CNT_W-1:0] count;
		logic [CRC_W-1:0] data_rem;
	} mid_item_t;

	// Advance matrix, one column per state bit
	typedef logic [CRC_W-1:0][CRC_W-1:0] mat_t;

	// Eight reflected shift steps over one value
	function automatic logic [CRC_W-1:0] crc64u_fold8(input logic [CRC_W-1:0] v,
		input logic [CRC_W-1:0] poly);
		logic [CRC_W-1:0] r;
		r = v;
		for (int b = 0; b < BYTE_W; b++) begin
			if (r[0]) begin
				r = (r >> 1) ^ poly;
			end else begin
				r = r >> 1;
			end
		end
		return r;
	endfunction

endpackage

@@ rtl/crc64u_front.sv @@
`timescale 1ns / 1ps
module crc64u_front import crc64u_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	output logic             full,
	input  logic [CRC_W-1:0] data_bytes,
	input  logic [CNT_W-1:0] byte_count,
	input  logic             restart,
	input  logic [CRC_W-1:0] poly,
	input  logic             busy,
	input  logic             mid_full,
	output logic             mid_push,
	output mid_item_t        mid_item
);

	logic             en;
	logic             acc_ok;
	logic [CNT_W-1:0] count_sat;

	// Stage 0 holds the raw word, stage k+1 has byte k folded in
	logic                vld_s  [0:LANES];
	logic [CRC_W-1:0]    acc_s  [0:LANES];
	logic [CRC_W-1:0]    data_s [0:LANES-1];
	logic [CNT_W-1:0]    cnt_s  [0:LANES];
	logic                rst_s  [0:LANES];

	// Whole pipe holds while the middle queue is full
	assign en        = !mid_full;
	assign full      = busy || mid_full;
	assign acc_ok    = push && !full;
	assign count_sat = (byte_count > CNT_W'(LANES)) ? CNT_W'(LANES) : byte_count;

	// Valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k <= LANES; k++) begin
				vld_s[k] <= 1'b0;
			end
		end else if (en) begin
			vld_s[0] <= acc_ok;
			for (int k = 1; k <= LANES; k++) begin
				vld_s[k] <= vld_s[k-1];
			end
		end
	end

	// Data-only contribution, one byte per stage; bytes past the count pass through
	always_ff @(posedge clk) begin
		if (en) begin
			data_s[0] <= data_bytes;
			acc_s[0]  <= '0;
			cnt_s[0]  <= count_sat;
			rst_s[0]  <= restart;
			for (int k = 0; k < LANES; k++) begin
				if (cnt_s[k] > CNT_W'(k)) begin
					acc_s[k+1] <= crc64u_fold8(acc_s[k] ^
						((data_s[k] >> (BYTE_W * k)) & BYTE_MASK), poly);
				end else begin
					acc_s[k+1] <= acc_s[k];
				end
				cnt_s[k+1] <= cnt_s[k];
				rst_s[k+1] <= rst_s[k];
			end
			for (int k = 1; k < LANES; k++) begin
				data_s[k] <= data_s[k-1];
			end
		end
	end

	assign mid_push          = en && vld_s[LANES];
	assign mid_item.restart  = rst_s[LANES];
	assign mid_item.count    = cnt_s[LANES];
	assign mid_item.data_rem = acc_s[LANES];

endmodule

@@ rtl/crc64u_queue.sv @@
`timescale 1ns / 1ps
module crc64u_queue import crc64u_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      wr_en,
	input  mid_item_t wr_item,
	output logic      full,
	input  logic      rd_en,
	output logic      rd_valid,
	output mid_item_t rd_item
);

	mid_item_t            mem_q [0:MID_DEPTH-1];
	logic [MID_PTR_W-1:0] wr_ptr_q;
	logic [MID_PTR_W-1:0] rd_ptr_q;
	logic [MID_CNT_W-1:0] cnt_q;
	logic                 do_wr;
	logic                 do_rd;

	assign full     = (cnt_q == MID_CNT_W'(MID_DEPTH));
	assign rd_valid = (cnt_q != '0);
	assign rd_item  = mem_q[rd_ptr_q];
	assign do_wr    = wr_en && !full;
	assign do_rd    = rd_en && rd_valid;

	// Pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (do_wr) begin
				wr_ptr_q <= wr_ptr_q + MID_PTR_W'(1);
			end
			if (do_rd) begin
				rd_ptr_q <= rd_ptr_q + MID_PTR_W'(1);
			end
			if (do_wr && !do_rd) begin
				cnt_q <= cnt_q + MID_CNT_W'(1);
			end else if (do_rd && !do_wr) begin
				cnt_q <= cnt_q - MID_CNT_W'(1);
			end
		end
	end

	// Storage
	always_ff @(posedge clk) begin
		if (do_wr) begin
			mem_q[wr_ptr_q] <= wr_item;
		end
	end

endmodule

@@ rtl/crc64u_back.sv @@
`timescale 1ns / 1ps
module crc64u_back import crc64u_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic [CRC_W-1:0] poly,
	input  logic [CRC_W-1:0] seed,
	input  logic             rebuild,
	output logic             busy,
	input  logic             mid_valid,
	input  mid_item_t        mid_item,
	output logic             mid_pop,
	input  logic             pop,
	output logic             empty,
	output logic [CRC_W-1:0] crc_value
);

	// Advance-matrix builder
	logic                  busy_q;
	logic [LANE_IDX_W-1:0] step_q;
	mat_t                  work_q;
	mat_t                  work_nxt;
	mat_t                  mat_q [0:LANES-1];

	// Loop stage
	logic             vld_s1;
	logic             rst_s1;
	logic [CRC_W-1:0] rem_s1;
	mat_t             mat_s1;
	logic [CRC_W-1:0] rh_q;
	logic [CRC_W-1:0] start_val;
	logic [CRC_W-1:0] prod;
	logic [CRC_W-1:0] res;
	logic [CNT_W-1:0] cnt_m1;

	// Result queue
	logic [CRC_W-1:0]     ofifo_q [0:OUT_DEPTH-1];
	logic [OUT_PTR_W-1:0] owr_ptr_q;
	logic [OUT_PTR_W-1:0] ord_ptr_q;
	logic [OUT_CNT_W-1:0] ocnt_q;
	logic                 o_wr;
	logic                 o_rd;

	assign busy = busy_q;

	// Next columns: folded identity at step 0, else the previous power folded
	always_comb begin
		for (int i = 0; i < CRC_W; i++) begin
			if (step_q == '0) begin
				work_nxt[i] = crc64u_fold8(CRC_W'(1) << i, poly);
			end else begin
				work_nxt[i] = crc64u_fold8(work_q[i], poly);
			end
		end
	end

	// Build sequencer: one power per cycle after reset or a polynomial write
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b1;
			step_q <= '0;
		end else if (rebuild) begin
			busy_q <= 1'b1;
			step_q <= '0;
		end else if (busy_q) begin
			step_q <= step_q + LANE_IDX_W'(1);
			if (step_q == LANE_IDX_W'(LANES - 1)) begin
				busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (busy_q && !rebuild) begin
			work_q         <= work_nxt;
			mat_q[step_q]  <= work_nxt;
		end
	end

	// Take a word only when the result queue has room for it and the one in flight
	assign mid_pop = mid_valid && !busy_q &&
		((ocnt_q + OUT_CNT_W'(vld_s1)) < OUT_CNT_W'(OUT_DEPTH));
	assign cnt_m1  = mid_item.count - CNT_W'(1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else begin
			vld_s1 <= mid_pop;
		end
	end

	// Matrix fetch for the word's byte count; zero bytes keeps the value
	always_ff @(posedge clk) begin
		if (mid_pop) begin
			rst_s1 <= mid_item.restart;
			rem_s1 <= mid_item.data_rem;
			if (mid_item.count == '0) begin
				for (int i = 0; i < CRC_W; i++) begin
					mat_s1[i] <= CRC_W'(1) << i;
				end
			end else begin
				mat_s1 <= mat_q[cnt_m1[LANE_IDX_W-1:0]];
			end
		end
	end

	// Running value update: advance the inverted state, add the data part
	always_comb begin
		start_val = ~(rst_s1 ? seed : rh_q);
		prod      = '0;
		for (int i = 0; i < CRC_W; i++) begin
			if (start_val[i]) begin
				prod = prod ^ mat_s1[i];
			end
		end
		res = ~(prod ^ rem_s1);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rh_q <= SEED_RESET;
		end else if (vld_s1) begin
			rh_q <= res;
		end
	end

	// Result queue
	assign o_wr      = vld_s1;
	assign empty     = (ocnt_q == '0);
	assign o_rd      = pop && !empty;
	assign crc_value = ofifo_q[ord_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			owr_ptr_q <= '0;
			ord_ptr_q <= '0;
			ocnt_q    <= '0;
		end else begin
			if (o_wr) begin
				owr_ptr_q <= owr_ptr_q + OUT_PTR_W'(1);
			end
			if (o_rd) begin
				ord_ptr_q <= ord_ptr_q + OUT_PTR_W'(1);
			end
			if (o_wr && !o_rd) begin
				ocnt_q <= ocnt_q + OUT_CNT_W'(1);
			end else if (o_rd && !o_wr) begin
				ocnt_q <= ocnt_q - OUT_CNT_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (o_wr) begin
			ofifo_q[owr_ptr_q] <= res;
		end
	end

endmodule

@@ rtl/crc64_reflected_update_top.sv @@
`timescale 1ns / 1ps
// Reflected CRC-64 update engine (CRC-64/XZ at reset values).
// Input side is a queue: drive data_bytes/byte_count/restart and raise push;
// the word is taken on a clock edge with push high and full low. byte_count
// of 0 folds nothing, values above 8 count as 8. restart reloads from seed.
// Result side is a queue too: crc_value is valid while empty is low and is
// taken on an edge with pop high. One result word per input word, in order.
// Throughput is one word per cycle while full is low: a running value feeds
// back through one precomputed advance matrix per byte count, while the data
// bytes are folded in the front pipe, one byte per stage after stage 0.
// Words go from the front pipe via the middle queue and loop stage to results.
// Config writes (cfg_we, cfg_index, cfg_wdata) land the same edge; index 0
// is the polynomial, index 1 the seed. After reset, and after each polynomial
// write, the advance matrices are rebuilt; full is held high meanwhile. Reset
// loads the default polynomial, a zero seed and a zero
// running value. When pop stays low the result queue fills, the middle queue
// backs up and full rises; nothing is dropped.
module crc64_reflected_update_top import crc64u_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 push,
	output logic                 full,
	input  logic [CRC_W-1:0]     data_bytes,
	input  logic [CNT_W-1:0]     byte_count,
	input  logic                 restart,
	output logic                 empty,
	input  logic                 pop,
	output logic [CRC_W-1:0]     crc_value,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CRC_W-1:0]     cfg_wdata
);

	logic [CRC_W-1:0] poly_q;
	logic [CRC_W-1:0] seed_q;
	logic             rebuild;
	logic             busy;
	logic             mid_full;
	logic             mid_push;
	mid_item_t        mid_wr_item;
	logic             mid_valid;
	logic             mid_pop;
	mid_item_t        mid_rd_item;

	// Config registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			poly_q <= POLY_RESET;
			seed_q <= SEED_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_POLY: poly_q <= cfg_wdata;
				REG_SEED: seed_q <= cfg_wdata;
			endcase
		end
	end

	assign rebuild = cfg_we && (cfg_index == REG_POLY);

	crc64u_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.full       (full),
		.data_bytes (data_bytes),
		.byte_count (byte_count),
		.restart    (restart),
		.poly       (poly_q),
		.busy       (busy),
		.mid_full   (mid_full),
		.mid_push   (mid_push),
		.mid_item   (mid_wr_item)
	);

	crc64u_queue u_mid (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (mid_push),
		.wr_item  (mid_wr_item),
		.full     (mid_full),
		.rd_en    (mid_pop),
		.rd_valid (mid_valid),
		.rd_item  (mid_rd_item)
	);

	crc64u_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.poly      (poly_q),
		.seed      (seed_q),
		.rebuild   (rebuild),
		.busy      (busy),
		.mid_valid (mid_valid),
		.mid_item  (mid_rd_item),
		.mid_pop   (mid_pop),
		.pop       (pop),
		.empty     (empty),
		.crc_value (crc_value)
	);

endmodule
